/* hw/rtl/shi_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shi_pkg
// Shared types and constants for the superscalar hazard interlock: the
// per-instruction flag word kept in every pipeline latch and the register map
// of the configuration port.
// ----------------------------------------------------------------------------
package shi_pkg;

    // flag word carried by each latch entry
    typedef struct packed {
        logic valid;
        logic misp;
        logic load;
        logic dest;
        logic src_a;
        logic src_b;
        logic cc_rd;
        logic cc_wr;
    } t_flags;

    localparam t_flags FLAGS_NONE = '0;

    // configuration register map, one word per register
    typedef enum logic [0:0] {
        CFG_FWD_EX = 1'b0,
        CFG_FWD_MA = 1'b1
    } t_cfg_idx;

    localparam int unsigned APB_ADDR_BITS = 3;
    localparam int unsigned APB_DATA_BITS = 32;

endpackage
`default_nettype wire

/* hw/rtl/shi_lane.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shi_lane
// Hazard check for one decode lane: compares the consumer in decode against
// the decode, execute and memory latches of all lanes and applies forwarding.
// ----------------------------------------------------------------------------
module shi_lane #(
    parameter int unsigned LANES    = 2,
    parameter int unsigned REG_BITS = 8,
    parameter int unsigned AGE_BITS = 32
) (
    input  shi_pkg::t_flags                               i_c_flags,
    input  logic [3*REG_BITS-1:0]                         i_c_regs,
    input  logic [AGE_BITS-1:0]                           i_c_age,
    input  shi_pkg::t_flags [LANES-1:0]                   i_id_flags,
    input  logic [LANES-1:0][3*REG_BITS-1:0]              i_id_regs,
    input  logic [LANES-1:0][AGE_BITS-1:0]                i_id_age,
    input  shi_pkg::t_flags [LANES-1:0]                   i_ex_flags,
    input  logic [LANES-1:0][3*REG_BITS-1:0]              i_ex_regs,
    input  logic [LANES-1:0][AGE_BITS-1:0]                i_ex_age,
    input  shi_pkg::t_flags [LANES-1:0]                   i_ma_flags,
    input  logic [LANES-1:0][3*REG_BITS-1:0]              i_ma_regs,
    input  logic [LANES-1:0][AGE_BITS-1:0]                i_ma_age,
    input  logic                                          i_fwd_ex,
    input  logic                                          i_fwd_ma,
    output logic                                          o_hazard
);
    import shi_pkg::*;

    logic                dep_id;
    logic                dep_ex;
    logic                dep_ma;
    logic                have_young;
    logic [AGE_BITS-1:0] young_age;
    logic                young_load;

    // read-after-write match on condition codes or a register source
    function automatic logic raw_hit(
        input t_flags                c,
        input logic [3*REG_BITS-1:0] cr,
        input t_flags                p,
        input logic [3*REG_BITS-1:0] pr
    );
        logic [REG_BITS-1:0] d;
        d = pr[REG_BITS-1:0];
        raw_hit = (c.cc_rd && p.cc_wr) ||
                  (p.dest && ((c.src_a && (cr[2*REG_BITS-1:REG_BITS] == d)) ||
                              (c.src_b && (cr[3*REG_BITS-1:2*REG_BITS] == d))));
    endfunction

    // producer scan over all lanes, tracking the youngest execute producer
    always_comb begin
        dep_id     = 1'b0;
        dep_ex     = 1'b0;
        dep_ma     = 1'b0;
        have_young = 1'b0;
        young_age  = '0;
        young_load = 1'b0;
        for (int j = 0; j < int'(LANES); j++) begin
            if (i_id_flags[j].valid && (i_c_age > i_id_age[j]) &&
                raw_hit(i_c_flags, i_c_regs, i_id_flags[j], i_id_regs[j])) begin
                dep_id = 1'b1;
            end
            if (i_ex_flags[j].valid && (i_c_age >= i_ex_age[j]) &&
                raw_hit(i_c_flags, i_c_regs, i_ex_flags[j], i_ex_regs[j])) begin
                dep_ex = 1'b1;
                if (!have_young || (i_ex_age[j] > young_age)) begin
                    have_young = 1'b1;
                    young_age  = i_ex_age[j];
                    young_load = i_ex_flags[j].load;
                end
            end
            if (i_ma_flags[j].valid && (i_c_age >= i_ma_age[j]) &&
                raw_hit(i_c_flags, i_c_regs, i_ma_flags[j], i_ma_regs[j])) begin
                dep_ma = 1'b1;
            end
        end
    end

    // nearest stage decides, forwarding may clear the stall
    always_comb begin
        priority if (!i_c_flags.valid) begin
            o_hazard = 1'b0;
        end else if (dep_id) begin
            o_hazard = 1'b1;
        end else if (dep_ex) begin
            o_hazard = !(i_fwd_ex && !young_load);
        end else begin
            o_hazard = dep_ma && !i_fwd_ma;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/shi_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// shi_merge
// Combines the per-lane hazard results: spreads a stall to younger lanes and
// hands the offered trace records to the unstalled lanes in lane order.
// ----------------------------------------------------------------------------
module shi_merge #(
    parameter int unsigned LANES    = 2,
    parameter int unsigned AGE_BITS = 32
) (
    input  logic [LANES-1:0]                                   i_hazard,
    input  logic [LANES-1:0]                                   i_id_valid,
    input  logic [LANES-1:0][AGE_BITS-1:0]                     i_id_age,
    input  logic                                               i_fetch_block,
    input  logic [$clog2(LANES+1)-1:0]                         i_nrec,
    input  logic [LANES-1:0]                                   i_misp,
    output logic [LANES-1:0]                                   o_stall,
    output logic [LANES-1:0]                                   o_take,
    output logic [LANES-1:0][((LANES > 1) ? $clog2(LANES) : 1)-1:0] o_sel,
    output logic [$clog2(LANES+1)-1:0]                         o_taken,
    output logic                                               o_trace_end,
    output logic                                               o_misp_taken
);
    localparam int unsigned CNT_W = $clog2(LANES + 1);
    localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    logic                            have_first;
    logic [AGE_BITS-1:0]             first_age;
    logic [CNT_W-1:0]                rank;
    logic [LANES-1:0][CNT_W-1:0]     rank_of;
    logic [CNT_W-1:0]                lim;
    logic                            misp_in;

    // first stalled lane in lane order stalls every younger valid lane
    always_comb begin
        have_first = 1'b0;
        first_age  = '0;
        for (int i = 0; i < int'(LANES); i++) begin
            if (!have_first && i_hazard[i]) begin
                have_first = 1'b1;
                first_age  = i_id_age[i];
            end
        end
        for (int y = 0; y < int'(LANES); y++) begin
            o_stall[y] = i_hazard[y] ||
                         (have_first && i_id_valid[y] && (i_id_age[y] > first_age));
        end
    end

    // rank of each unstalled lane among the fetching lanes
    always_comb begin
        rank = '0;
        for (int i = 0; i < int'(LANES); i++) begin
            rank_of[i] = rank;
            if (!o_stall[i]) begin
                rank = rank + 1'b1;
            end
        end
    end

    // fetch stops after the first mispredicted record
    always_comb begin
        lim     = i_nrec;
        misp_in = 1'b0;
        for (int m = int'(LANES) - 1; m >= 0; m--) begin
            if ((CNT_W'(m) < i_nrec) && i_misp[m]) begin
                lim     = CNT_W'(m + 1);
                misp_in = 1'b1;
            end
        end
    end

    // fetch allocation
    always_comb begin
        if (i_fetch_block) begin
            o_taken = '0;
        end else if (rank < lim) begin
            o_taken = rank;
        end else begin
            o_taken = lim;
        end
        for (int i = 0; i < int'(LANES); i++) begin
            o_take[i] = !o_stall[i] && (rank_of[i] < o_taken);
            o_sel[i]  = rank_of[i][IDX_W-1:0];
        end
        o_trace_end  = !i_fetch_block && !misp_in && (rank > i_nrec);
        o_misp_taken = misp_in && (o_taken == lim);
    end

endmodule
`default_nettype wire

/* hw/rtl/superscalar_hazard_interlock.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// superscalar_hazard_interlock
// Pipeline latch model of a LANES-wide in-order core with register and
// condition-code interlocks; each request is one clock tick of that core.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+----------------------------------------
//  in      | i_in_valid / o_in_ready    | record count, per-record flags, regs
//  out     | o_out_valid / i_out_ready  | records taken, retired, stalls, halted
//  cfg     | psel penable pwrite pready | forward enables at 0x0 and 0x4
//
//  One request is accepted per cycle; its result is registered at the accepting
//  edge and offered from the next cycle. Latency and throughput are set by the
//  single stage that holds the hazard lanes, the merge and the fetch allocation.
//  o_in_ready drops only while a result waits in the output register and the
//  sink is not ready. After reset all latches are empty, both forward enables
//  are set, and the trace end age is all ones.
// ----------------------------------------------------------------------------
module superscalar_hazard_interlock #(
    parameter int unsigned LANES    = 2,
    parameter int unsigned REG_BITS = 8,
    parameter int unsigned AGE_BITS = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // request channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [$clog2(LANES+1)-1:0]            i_record_count,
    input  logic [LANES-1:0]                      i_load_flags,
    input  logic [LANES-1:0]                      i_dest_used_flags,
    input  logic [LANES*REG_BITS-1:0]             i_dest_regs,
    input  logic [LANES-1:0]                      i_src_a_used_flags,
    input  logic [LANES*REG_BITS-1:0]             i_src_a_regs,
    input  logic [LANES-1:0]                      i_src_b_used_flags,
    input  logic [LANES*REG_BITS-1:0]             i_src_b_regs,
    input  logic [LANES-1:0]                      i_cc_reads,
    input  logic [LANES-1:0]                      i_cc_writes,
    input  logic [LANES-1:0]                      i_mispredict_flags,
    // result channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [$clog2(LANES+1)-1:0]            o_records_taken,
    output logic [$clog2(LANES+1)-1:0]            o_retired_count,
    output logic [LANES-1:0]                      o_decode_stall_flags,
    output logic                                  o_halted,
    // configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [shi_pkg::APB_ADDR_BITS-1:0]     paddr,
    input  logic [shi_pkg::APB_DATA_BITS-1:0]     pwdata,
    output logic [shi_pkg::APB_DATA_BITS-1:0]     prdata,
    output logic                                  pready
);
    import shi_pkg::*;

    localparam int unsigned CNT_W = $clog2(LANES + 1);
    localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int unsigned RW    = 3 * REG_BITS;

    // pipeline latches
    t_flags [LANES-1:0]              r_if_flags, r_id_flags, r_ex_flags, r_ma_flags;
    logic   [LANES-1:0][RW-1:0]      r_if_regs,  r_id_regs,  r_ex_regs,  r_ma_regs;
    logic   [LANES-1:0][AGE_BITS-1:0] r_if_age,  r_id_age,   r_ex_age,   r_ma_age;
    logic   [LANES-1:0]              r_id_stall;

    // sequencing state and configuration
    logic [AGE_BITS-1:0]  r_last_age, n_last_age;
    logic [AGE_BITS-1:0]  r_final_age, n_final_age;
    logic                 r_bfs, n_bfs;
    logic                 r_halt, n_halt;
    logic                 r_fwd_ex, r_fwd_ma;

    // output register
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_out_taken, r_out_retired;
    logic [LANES-1:0]     r_out_stall;
    logic                 r_out_halt;

    // next fetch latch contents
    t_flags [LANES-1:0]               n_if_flags;
    logic   [LANES-1:0][RW-1:0]       n_if_regs;
    logic   [LANES-1:0][AGE_BITS-1:0] n_if_age;

    logic                      in_accept;
    logic [CNT_W-1:0]          nrec;
    logic [CNT_W-1:0]          retired;
    logic                      misp_retire;
    logic                      halt_hit;
    logic                      bfs_wb;
    t_flags [LANES-1:0]        ex_view_flags;
    logic [LANES-1:0]          if_valid;
    logic [LANES-1:0]          hazard;
    logic [LANES-1:0]          stall;
    logic [LANES-1:0]          take;
    logic [LANES-1:0][IDX_W-1:0] sel;
    logic [CNT_W-1:0]          taken;
    logic                      trace_end;
    logic                      misp_taken;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // clamp the record count to the lane count
    assign nrec = (i_record_count > CNT_W'(LANES)) ? CNT_W'(LANES) : i_record_count;

    // write-back of the memory latch
    always_comb begin
        retired     = '0;
        misp_retire = 1'b0;
        halt_hit    = 1'b0;
        for (int i = 0; i < int'(LANES); i++) begin
            if (r_ma_flags[i].valid) begin
                retired = retired + 1'b1;
                if (r_ma_flags[i].misp) begin
                    misp_retire = 1'b1;
                end
                if (r_ma_age[i] >= r_final_age) begin
                    halt_hit = 1'b1;
                end
            end
        end
    end

    assign bfs_wb = r_bfs && !misp_retire;

    // decode lanes that stalled last tick enter execute as bubbles
    always_comb begin
        for (int i = 0; i < int'(LANES); i++) begin
            ex_view_flags[i]       = r_id_flags[i];
            ex_view_flags[i].valid = r_id_flags[i].valid && !r_id_stall[i];
            if_valid[i]            = r_if_flags[i].valid;
        end
    end

    // per-lane hazard checks on the instructions entering decode
    for (genvar g = 0; g < int'(LANES); g++) begin : g_lane
        shi_lane #(
            .LANES    (LANES),
            .REG_BITS (REG_BITS),
            .AGE_BITS (AGE_BITS)
        ) u_lane (
            .i_c_flags  (r_if_flags[g]),
            .i_c_regs   (r_if_regs[g]),
            .i_c_age    (r_if_age[g]),
            .i_id_flags (r_if_flags),
            .i_id_regs  (r_if_regs),
            .i_id_age   (r_if_age),
            .i_ex_flags (ex_view_flags),
            .i_ex_regs  (r_id_regs),
            .i_ex_age   (r_id_age),
            .i_ma_flags (r_ex_flags),
            .i_ma_regs  (r_ex_regs),
            .i_ma_age   (r_ex_age),
            .i_fwd_ex   (r_fwd_ex),
            .i_fwd_ma   (r_fwd_ma),
            .o_hazard   (hazard[g])
        );
    end

    // stall spreading and fetch allocation
    shi_merge #(
        .LANES    (LANES),
        .AGE_BITS (AGE_BITS)
    ) u_merge (
        .i_hazard      (hazard),
        .i_id_valid    (if_valid),
        .i_id_age      (r_if_age),
        .i_fetch_block (bfs_wb),
        .i_nrec        (nrec),
        .i_misp        (i_mispredict_flags),
        .o_stall       (stall),
        .o_take        (take),
        .o_sel         (sel),
        .o_taken       (taken),
        .o_trace_end   (trace_end),
        .o_misp_taken  (misp_taken)
    );

    // fetch latch refill: stalled lanes hold, unfilled lanes go empty
    always_comb begin
        for (int i = 0; i < int'(LANES); i++) begin
            n_if_flags[i] = r_if_flags[i];
            n_if_regs[i]  = r_if_regs[i];
            n_if_age[i]   = r_if_age[i];
            if (!stall[i]) begin
                if (take[i]) begin
                    n_if_flags[i].valid = 1'b1;
                    n_if_flags[i].misp  = i_mispredict_flags[sel[i]];
                    n_if_flags[i].load  = i_load_flags[sel[i]];
                    n_if_flags[i].dest  = i_dest_used_flags[sel[i]];
                    n_if_flags[i].src_a = i_src_a_used_flags[sel[i]];
                    n_if_flags[i].src_b = i_src_b_used_flags[sel[i]];
                    n_if_flags[i].cc_rd = i_cc_reads[sel[i]];
                    n_if_flags[i].cc_wr = i_cc_writes[sel[i]];
                    n_if_regs[i] = {i_src_b_regs[sel[i]*REG_BITS +: REG_BITS],
                                    i_src_a_regs[sel[i]*REG_BITS +: REG_BITS],
                                    i_dest_regs[sel[i]*REG_BITS +: REG_BITS]};
                    n_if_age[i]  = r_last_age + AGE_BITS'(sel[i]) + AGE_BITS'(1);
                end else begin
                    n_if_flags[i] = FLAGS_NONE;
                end
            end
        end
    end

    // trace bookkeeping
    always_comb begin
        n_last_age  = r_last_age + AGE_BITS'(taken);
        n_final_age = trace_end ? n_last_age : r_final_age;
        n_halt      = r_halt || halt_hit || (trace_end && (n_last_age == '0));
        n_bfs       = bfs_wb || misp_taken;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_flags  <= '0;
            r_id_flags  <= '0;
            r_ex_flags  <= '0;
            r_ma_flags  <= '0;
            r_id_stall  <= '0;
            r_last_age  <= '0;
            r_final_age <= '1;
            r_bfs       <= 1'b0;
            r_halt      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_ma_flags  <= r_ex_flags;
                r_ex_flags  <= ex_view_flags;
                r_id_flags  <= r_if_flags;
                r_if_flags  <= n_if_flags;
                r_id_stall  <= stall;
                r_last_age  <= n_last_age;
                r_final_age <= n_final_age;
                r_bfs       <= n_bfs;
                r_halt      <= n_halt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch payload and result fields
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_ma_regs     <= r_ex_regs;
            r_ma_age      <= r_ex_age;
            r_ex_regs     <= r_id_regs;
            r_ex_age      <= r_id_age;
            r_id_regs     <= r_if_regs;
            r_id_age      <= r_if_age;
            r_if_regs     <= n_if_regs;
            r_if_age      <= n_if_age;
            r_out_taken   <= taken;
            r_out_retired <= retired;
            r_out_stall   <= stall;
            r_out_halt    <= n_halt;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_records_taken      = r_out_taken;
    assign o_retired_count      = r_out_retired;
    assign o_decode_stall_flags = r_out_stall;
    assign o_halted             = r_out_halt;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_ex <= 1'b1;
            r_fwd_ma <= 1'b1;
        end else if (psel && penable && pwrite) begin
            unique case (t_cfg_idx'(paddr[2]))
                CFG_FWD_EX: r_fwd_ex <= pwdata[0];
                CFG_FWD_MA: r_fwd_ma <= pwdata[0];
                default:    r_fwd_ex <= r_fwd_ex;
            endcase
        end
    end

    // configuration readback
    always_comb begin
        unique case (t_cfg_idx'(paddr[2]))
            CFG_FWD_EX: prdata = APB_DATA_BITS'(r_fwd_ex);
            CFG_FWD_MA: prdata = APB_DATA_BITS'(r_fwd_ma);
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // halt never clears once set
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag dropped");

    // only valid decode lanes can be stalled
    a_stall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> ((stall & ~if_valid) == '0))
        else $error("stall on an empty decode lane");

    // a pending mispredict blocks all fetch
    a_fetch_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && bfs_wb) |-> (taken == '0))
        else $error("fetch while mispredict pending");

    // trace state moves only with a request
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> ($stable(r_last_age) && $stable(r_bfs)))
        else $error("trace state changed without a request");

endmodule
`default_nettype wire

/* dv/superscalar_hazard_interlock_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superscalar_hazard_interlock_tb
// Drives pipeline tick requests into the hazard interlock and checks every
// result against a cycle model of the IF/ID/EX/MA latches kept in the bench.
// A short directed sequence covers forwarding, load-use, condition codes,
// mispredict fetch blocking, count clamping, trace end and halt. Random
// phases then run under each forwarding setting with random stalls on both
// channels, one long sink hold-off and one stretch with no idling.
// ----------------------------------------------------------------------------
module superscalar_hazard_interlock_tb;

    import shi_pkg::*;

    localparam int LANES    = 2;
    localparam int REG_BITS = 8;
    localparam int AGE_BITS = 32;
    localparam int CNT_BITS = $clog2(LANES + 1);

    // pipeline stage indexes
    localparam int STG_IF = 0;
    localparam int STG_ID = 1;
    localparam int STG_EX = 2;
    localparam int STG_MA = 3;

    localparam int HOLD_OFF_CYCLES = 60;
    localparam int IDLE_PCT        = 15;
    localparam int PHASE_TICKS     = 285;

    typedef struct packed {
        logic [CNT_BITS-1:0]       count;
        logic [LANES-1:0]          load;
        logic [LANES-1:0]          dest_used;
        logic [LANES*REG_BITS-1:0] dest;
        logic [LANES-1:0]          src_a_used;
        logic [LANES*REG_BITS-1:0] src_a;
        logic [LANES-1:0]          src_b_used;
        logic [LANES*REG_BITS-1:0] src_b;
        logic [LANES-1:0]          cc_rd;
        logic [LANES-1:0]          cc_wr;
        logic [LANES-1:0]          misp;
    } t_tick_req;

    typedef struct packed {
        logic [CNT_BITS-1:0] taken;
        logic [CNT_BITS-1:0] retired;
        logic [LANES-1:0]    stalls;
        logic                halted;
    } t_tick_res;

    typedef struct packed {
        logic [AGE_BITS-1:0] age;
        logic [REG_BITS-1:0] dst;
        logic [REG_BITS-1:0] src_a;
        logic [REG_BITS-1:0] src_b;
        t_flags              fl;
        logic                stall;
    } t_latch;

    // dut ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [CNT_BITS-1:0]       i_record_count = '0;
    logic [LANES-1:0]          i_load_flags = '0;
    logic [LANES-1:0]          i_dest_used_flags = '0;
    logic [LANES*REG_BITS-1:0] i_dest_regs = '0;
    logic [LANES-1:0]          i_src_a_used_flags = '0;
    logic [LANES*REG_BITS-1:0] i_src_a_regs = '0;
    logic [LANES-1:0]          i_src_b_used_flags = '0;
    logic [LANES*REG_BITS-1:0] i_src_b_regs = '0;
    logic [LANES-1:0]          i_cc_reads = '0;
    logic [LANES-1:0]          i_cc_writes = '0;
    logic [LANES-1:0]          i_mispredict_flags = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [CNT_BITS-1:0]       o_records_taken;
    logic [CNT_BITS-1:0]       o_retired_count;
    logic [LANES-1:0]          o_decode_stall_flags;
    logic                      o_halted;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    // bench state
    t_tick_req offered_ticks[$];
    t_tick_res expected_tick_results[$];
    t_tick_req cur_req = '0;
    int        sent_count = 0;
    int        acc_count = 0;
    bit        steady = 1'b0;
    bit        rx_hold_req = 1'b0;
    bit        rx_hold_used = 1'b0;
    int        rx_hold_left = 0;
    int        fail_count = 0;
    int        cfg_fail_count = 0;

    // pipeline model state
    t_latch              pipe[4][LANES];
    logic [AGE_BITS-1:0] issued_age;
    logic [AGE_BITS-1:0] trace_end_age;
    logic                fetch_blocked;
    logic                halt_seen;
    logic                fwd_ex_en = 1'b1;
    logic                fwd_ma_en = 1'b1;

    superscalar_hazard_interlock #(
        .LANES    (LANES),
        .REG_BITS (REG_BITS),
        .AGE_BITS (AGE_BITS)
    ) DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_record_count       (i_record_count),
        .i_load_flags         (i_load_flags),
        .i_dest_used_flags    (i_dest_used_flags),
        .i_dest_regs          (i_dest_regs),
        .i_src_a_used_flags   (i_src_a_used_flags),
        .i_src_a_regs         (i_src_a_regs),
        .i_src_b_used_flags   (i_src_b_used_flags),
        .i_src_b_regs         (i_src_b_regs),
        .i_cc_reads           (i_cc_reads),
        .i_cc_writes          (i_cc_writes),
        .i_mispredict_flags   (i_mispredict_flags),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_records_taken      (o_records_taken),
        .o_retired_count      (o_retired_count),
        .o_decode_stall_flags (o_decode_stall_flags),
        .o_halted             (o_halted),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // pipeline model
    // ------------------------------------------------------------------
    function automatic void clear_pipeline();
        for (int s = 0; s < 4; s++) begin
            for (int l = 0; l < LANES; l++) begin
                pipe[s][l] = '0;
            end
        end
        issued_age    = '0;
        trace_end_age = '1;
        fetch_blocked = 1'b0;
        halt_seen     = 1'b0;
    endfunction

    // consumer reads something the producer writes
    function automatic bit reads_result(t_latch c, t_latch p);
        if (c.fl.cc_rd && p.fl.cc_wr) return 1'b1;
        if (p.fl.dest) begin
            if (c.fl.src_a && c.src_a == p.dst) return 1'b1;
            if (c.fl.src_b && c.src_b == p.dst) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_tick_res advance_tick(t_tick_req r);
        t_tick_res           res;
        t_latch              c;
        t_latch              p;
        t_latch              f;
        int                  nrec;
        int                  k;
        bit                  dep_id;
        bit                  dep_ex;
        bit                  dep_ma;
        bit                  stl;
        bit                  have_young;
        bit                  young_load;
        logic [AGE_BITS-1:0] young_age;

        res  = '0;
        nrec = (r.count > LANES) ? LANES : int'(r.count);

        // write-back
        for (int i = 0; i < LANES; i++) begin
            if (pipe[STG_MA][i].fl.valid) begin
                res.retired++;
                if (pipe[STG_MA][i].fl.misp) fetch_blocked = 1'b0;
                if (pipe[STG_MA][i].age >= trace_end_age) halt_seen = 1'b1;
            end
        end

        // latch shift, bubbles behind stalled decode lanes
        for (int i = 0; i < LANES; i++) begin
            pipe[STG_MA][i] = pipe[STG_EX][i];
            pipe[STG_EX][i] = pipe[STG_ID][i];
            if (pipe[STG_ID][i].stall) begin
                pipe[STG_EX][i].fl.valid = 1'b0;
                pipe[STG_EX][i].stall    = 1'b0;
            end
            pipe[STG_ID][i]       = pipe[STG_IF][i];
            pipe[STG_ID][i].stall = 1'b0;
        end

        // raw hazards: within decode, then execute, then memory
        for (int i = 0; i < LANES; i++) begin
            c = pipe[STG_ID][i];
            if (!c.fl.valid) continue;
            dep_id     = 1'b0;
            dep_ex     = 1'b0;
            dep_ma     = 1'b0;
            stl        = 1'b0;
            have_young = 1'b0;
            young_load = 1'b0;
            young_age  = '0;
            for (int j = 0; j < LANES; j++) begin
                p = pipe[STG_ID][j];
                if (p.fl.valid && c.age > p.age && reads_result(c, p)) dep_id = 1'b1;
            end
            if (dep_id) begin
                stl = 1'b1;
            end else begin
                for (int j = 0; j < LANES; j++) begin
                    p = pipe[STG_EX][j];
                    if (p.fl.valid && c.age >= p.age && reads_result(c, p)) begin
                        dep_ex = 1'b1;
                        if (!have_young || p.age > young_age) begin
                            have_young = 1'b1;
                            young_age  = p.age;
                            young_load = p.fl.load;
                        end
                    end
                end
                if (dep_ex) begin
                    stl = !(fwd_ex_en && !young_load);
                end else begin
                    for (int j = 0; j < LANES; j++) begin
                        p = pipe[STG_MA][j];
                        if (p.fl.valid && c.age >= p.age && reads_result(c, p)) dep_ma = 1'b1;
                    end
                    if (dep_ma) stl = !fwd_ma_en;
                end
            end
            if (stl) pipe[STG_ID][i].stall = 1'b1;
        end

        // first stalled lane drags every younger lane with it
        for (int i = 0; i < LANES; i++) begin
            if (pipe[STG_ID][i].stall) begin
                for (int j = 0; j < LANES; j++) begin
                    if (pipe[STG_ID][j].fl.valid && pipe[STG_ID][j].age > pipe[STG_ID][i].age)
                        pipe[STG_ID][j].stall = 1'b1;
                end
                break;
            end
        end

        // fetch into unstalled lanes
        k = 0;
        for (int i = 0; i < LANES; i++) begin
            if (pipe[STG_ID][i].stall) begin
                res.stalls[i] = 1'b1;
                continue;
            end
            if (fetch_blocked) begin
                pipe[STG_IF][i] = '0;
                continue;
            end
            if (k >= nrec) begin
                pipe[STG_IF][i] = '0;
                trace_end_age   = issued_age;
                if (issued_age == '0) halt_seen = 1'b1;
                continue;
            end
            issued_age   = issued_age + 1'b1;
            f            = '0;
            f.fl.valid   = 1'b1;
            f.fl.load    = r.load[k];
            f.fl.dest    = r.dest_used[k];
            f.fl.src_a   = r.src_a_used[k];
            f.fl.src_b   = r.src_b_used[k];
            f.fl.cc_rd   = r.cc_rd[k];
            f.fl.cc_wr   = r.cc_wr[k];
            f.fl.misp    = r.misp[k];
            f.age        = issued_age;
            f.dst        = r.dest[k*REG_BITS +: REG_BITS];
            f.src_a      = r.src_a[k*REG_BITS +: REG_BITS];
            f.src_b      = r.src_b[k*REG_BITS +: REG_BITS];
            pipe[STG_IF][i] = f;
            if (f.fl.misp) fetch_blocked = 1'b1;
            k++;
            res.taken++;
        end

        res.halted = halt_seen;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_tick_req mk_tick(
        input logic [1:0] n,
        input logic [1:0] ld, input logic [1:0] du, input logic [7:0] d0, input logic [7:0] d1,
        input logic [1:0] au, input logic [7:0] a0, input logic [7:0] a1,
        input logic [1:0] bu, input logic [7:0] b0, input logic [7:0] b1,
        input logic [1:0] cr, input logic [1:0] cw, input logic [1:0] mp
    );
        t_tick_req r;
        r.count      = n;
        r.load       = ld;
        r.dest_used  = du;
        r.dest       = {d1, d0};
        r.src_a_used = au;
        r.src_a      = {a1, a0};
        r.src_b_used = bu;
        r.src_b      = {b1, b0};
        r.cc_rd      = cr;
        r.cc_wr      = cw;
        r.misp       = mp;
        return r;
    endfunction

    // mostly full ticks over a small register pool, some noise
    function automatic t_tick_req rand_tick();
        t_tick_req r;
        int        sel;
        bit        wide;
        sel  = $urandom_range(0, 99);
        wide = ($urandom_range(0, 99) < 20);
        if (sel < 78)      r.count = 2'd2;
        else if (sel < 88) r.count = 2'd1;
        else if (sel < 94) r.count = 2'd0;
        else               r.count = 2'd3;
        r.load       = LANES'($urandom_range(0, 3));
        r.dest_used  = LANES'($urandom_range(0, 3));
        r.src_a_used = LANES'($urandom_range(0, 3));
        r.src_b_used = LANES'($urandom_range(0, 3));
        r.cc_rd      = LANES'($urandom_range(0, 3));
        r.cc_wr      = LANES'($urandom_range(0, 3));
        r.misp[0]    = ($urandom_range(0, 99) < 6);
        r.misp[1]    = ($urandom_range(0, 99) < 6);
        for (int l = 0; l < LANES; l++) begin
            r.dest[l*REG_BITS +: REG_BITS]  =
                REG_BITS'(wide ? $urandom_range(0, 255) : $urandom_range(0, 3));
            r.src_a[l*REG_BITS +: REG_BITS] =
                REG_BITS'(wide ? $urandom_range(0, 255) : $urandom_range(0, 3));
            r.src_b[l*REG_BITS +: REG_BITS] =
                REG_BITS'(wide ? $urandom_range(0, 255) : $urandom_range(0, 3));
        end
        return r;
    endfunction

    // reports a mismatch and returns 1 when the values differ
    function automatic bit check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // apb write, register updates at the access edge
    task automatic cfg_write(input t_cfg_idx idx, input logic v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'b0, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == CFG_FWD_EX) fwd_ex_en = v;
        else                   fwd_ma_en = v;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_read_check(input t_cfg_idx idx, input logic v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (check_field("prdata", {31'b0, v}, prdata)) cfg_fail_count++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_forwarding(input logic ex_v, input logic ma_v);
        cfg_write(CFG_FWD_EX, ex_v);
        cfg_write(CFG_FWD_MA, ma_v);
        cfg_read_check(CFG_FWD_EX, ex_v);
        cfg_read_check(CFG_FWD_MA, ma_v);
    endtask

    // wait until every request is in and every result is out
    task automatic drain();
        while (offered_ticks.size() != 0 || sent_count != acc_count ||
               expected_tick_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (sent_count == acc_count) begin
            if (offered_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_req = offered_ticks.pop_front();
                sent_count++;
                i_record_count     <= cur_req.count;
                i_load_flags       <= cur_req.load;
                i_dest_used_flags  <= cur_req.dest_used;
                i_dest_regs        <= cur_req.dest;
                i_src_a_used_flags <= cur_req.src_a_used;
                i_src_a_regs       <= cur_req.src_a;
                i_src_b_used_flags <= cur_req.src_b_used;
                i_src_b_regs       <= cur_req.src_b;
                i_cc_reads         <= cur_req.cc_rd;
                i_cc_writes        <= cur_req.cc_wr;
                i_mispredict_flags <= cur_req.misp;
                i_in_valid         <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // accepted request feeds the model, model cleared while in reset
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_pipeline();
        end else if (i_in_valid && o_in_ready) begin
            expected_tick_results.push_back(advance_tick(cur_req));
            acc_count++;
        end
    end

    // sink ready, with one long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req && !rx_hold_used) begin
            rx_hold_left = HOLD_OFF_CYCLES;
            rx_hold_used = 1'b1;
        end
        if (rx_hold_left > 0) begin
            i_out_ready <= 1'b0;
            rx_hold_left--;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_tick_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_tick_results.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                e = expected_tick_results.pop_front();
                if (check_field("records_taken", 32'(e.taken), 32'(o_records_taken)))
                    fail_count++;
                if (check_field("retired_count", 32'(e.retired), 32'(o_retired_count)))
                    fail_count++;
                if (check_field("decode_stall_flags", 32'(e.stalls),
                                32'(o_decode_stall_flags)))
                    fail_count++;
                if (check_field("halted", 32'(e.halted), 32'(o_halted)))
                    fail_count++;
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [1:0] fwd_plan[5];
        fwd_plan = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of the forward enables
        cfg_read_check(CFG_FWD_EX, 1'b1);
        cfg_read_check(CFG_FWD_MA, 1'b1);

        // directed: nops and all-ones extremes
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(2, 3, 3, 8'hff, 8'hff, 3, 8'hff, 8'hff,
                                        3, 8'hff, 8'hff, 3, 3, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        // load then dependent read against execute
        offered_ticks.push_back(mk_tick(2, 1, 1, 8'h05, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 3, 8'h05, 8'h06,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        // alu producer then second-source reader, forwarded from execute
        offered_ticks.push_back(mk_tick(2, 0, 2, 8'h00, 8'h07, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        1, 8'h07, 8'h00, 0, 0, 0));
        // producer, gap, reader against memory
        offered_ticks.push_back(mk_tick(2, 0, 1, 8'h09, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 2, 8'h00, 8'h09,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        // condition codes within decode and against execute
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 2, 1, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 2, 0));
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 1, 0, 0));
        // mispredict blocks fetch until it retires
        offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 1, 1));
        repeat (4) offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                                   0, 8'h00, 8'h00, 0, 0, 0));
        // record count above lane count is clamped
        offered_ticks.push_back(mk_tick(3, 2, 3, 8'h01, 8'h02, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        // trace end, then halt once the last instruction retires
        offered_ticks.push_back(mk_tick(1, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        offered_ticks.push_back(mk_tick(0, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                        0, 8'h00, 8'h00, 0, 0, 0));
        repeat (3) offered_ticks.push_back(mk_tick(2, 0, 0, 8'h00, 8'h00, 0, 8'h00, 8'h00,
                                                   0, 8'h00, 8'h00, 0, 0, 0));
        drain();

        // random phases across forwarding settings
        for (int ph = 0; ph < 5; ph++) begin
            set_forwarding(fwd_plan[ph][0], fwd_plan[ph][1]);
            steady = (ph == 3);
            for (int n = 0; n < PHASE_TICKS; n++) offered_ticks.push_back(rand_tick());
            if (ph == 1) rx_hold_req = 1'b1;
            drain();
        end
        steady = 1'b0;

        drain();
        repeat (5) @(posedge i_clk);
        if (fail_count == 0 && cfg_fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
